[hw/rtl/smf_pkg.sv]
// Package for the salary mode finder: table sizes, field widths and the sequencer states.
// It has no dependencies. The core module imports it.
`default_nettype none

package smf_pkg;

   localparam int CAPACITY    = 32;
   localparam int MAX_RESULTS = 32;

   localparam int VALUE_W = 31;
   localparam int COUNT_W = 6;
   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int USED_W  = $clog2(CAPACITY + 1);

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SEARCH = 5'b00010,
      ST_MAX    = 5'b00100,
      ST_NOMODE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/salary_mode_finder_core.sv]
// Mode finder over a run of amounts in cents, with a value table and a count table.
// The tables are searched one entry per cycle through a single read port.
// Each item is searched against the stored values. After the last item, a maximum scan
// finds the best count, then an emit scan sends the values with it and may stall on the response.
// A new item is taken only in the idle state, once the previous one is through.
// Reset clears the sequencer, the fill count and the overflow flag. The tables are not cleared.
`default_nettype none

module salary_mode_finder_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [smf_pkg::REQ_DATA_W-1:0]      req_tdata,  // [30:0] value_cents, [31] zero
   input  wire                                 req_tlast,  // last_item
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [smf_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [30:0] mode_value, [36:31] occurrences,
                                                           // [37] overflowed, [39:38] zero
   output logic                                rsp_tuser,  // status
   output logic                                rsp_tlast   // last_result
);
   import smf_pkg::*;

   logic [VALUE_W-1:0] value_mem [CAPACITY];
   logic [COUNT_W-1:0] count_mem [CAPACITY];

   state_type           state_ff, state_in;
   logic [VALUE_W-1:0]  item_value_ff, item_value_in;
   logic                item_last_ff, item_last_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic                ovf_ff, ovf_in;
   logic [USED_W-1:0]   addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   logic [COUNT_W-1:0]  best_ff, best_in;
   logic [USED_W-1:0]   ties_ff, ties_in;
   logic [USED_W-1:0]   limit_ff, limit_in;
   logic [USED_W-1:0]   emitted_ff, emitted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_ovf_ff, rsp_status_ff, rsp_last_ff;
   logic [VALUE_W-1:0]  val_rd_ff;
   logic [COUNT_W-1:0]  cnt_rd_ff;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_val_en, wr_cnt_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [VALUE_W-1:0]  wr_val;
   logic [COUNT_W-1:0]  wr_cnt;
   logic                out_free, out_load;
   logic [VALUE_W-1:0]  out_value;
   logic [COUNT_W-1:0]  out_count;
   logic                out_status, out_last;
   logic                issue_ok, hit, take;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign issue_ok = addr_ff < used_ff;
   assign rd_addr  = addr_ff[IDX_W-1:0];
   assign hit      = pend_ff && (val_rd_ff == item_value_ff);
   assign take     = pend_ff && (cnt_rd_ff == best_ff);

   always_comb begin
      state_in      = state_ff;
      item_value_in = item_value_ff;
      item_last_in  = item_last_ff;
      used_in       = used_ff;
      ovf_in        = ovf_ff;
      addr_in       = addr_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      best_in       = best_ff;
      ties_in       = ties_ff;
      limit_in      = limit_ff;
      emitted_in    = emitted_ff;
      rd_en         = 1'b0;
      wr_val_en     = 1'b0;
      wr_cnt_en     = 1'b0;
      wr_addr       = used_ff[IDX_W-1:0];
      wr_val        = item_value_ff;
      wr_cnt        = COUNT_W'(1);
      out_load      = 1'b0;
      out_value     = '0;
      out_count     = COUNT_W'(1);
      out_status    = 1'b1;
      out_last      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_value_in = req_tdata[VALUE_W-1:0];
               item_last_in  = req_tlast;
               addr_in       = '0;
               pend_in       = 1'b0;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (hit || !issue_ok) begin
               if (hit) begin
                  wr_cnt_en = 1'b1;
                  wr_addr   = pidx_ff;
                  wr_cnt    = (cnt_rd_ff == COUNT_MAX) ? cnt_rd_ff : cnt_rd_ff + COUNT_W'(1);
               end else if (used_ff < USED_W'(CAPACITY)) begin
                  wr_val_en = 1'b1;
                  wr_cnt_en = 1'b1;
                  used_in   = used_ff + USED_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               pend_in = 1'b0;
               addr_in = '0;
               if (item_last_ff) begin
                  best_in  = '0;
                  ties_in  = '0;
                  state_in = ST_MAX;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               pidx_in = addr_ff[IDX_W-1:0];
               addr_in = addr_ff + USED_W'(1);
            end
         end
         ST_MAX: begin
            if (pend_ff) begin
               if (cnt_rd_ff > best_ff) begin
                  best_in = cnt_rd_ff;
                  ties_in = USED_W'(1);
               end else if (cnt_rd_ff == best_ff) begin
                  ties_in = ties_ff + USED_W'(1);
               end
            end
            if (issue_ok) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               addr_in = addr_ff + USED_W'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  addr_in    = '0;
                  emitted_in = '0;
                  limit_in   = (int'(ties_ff) > MAX_RESULTS) ? USED_W'(MAX_RESULTS) : ties_ff;
                  state_in   = (best_ff <= COUNT_W'(1)) ? ST_NOMODE : ST_EMIT;
               end
            end
         end
         ST_NOMODE: begin
            if (out_free) begin
               out_load = 1'b1;
               used_in  = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!(take && !out_free)) begin
               if (take) begin
                  out_load   = 1'b1;
                  out_value  = val_rd_ff;
                  out_count  = best_ff;
                  out_status = 1'b0;
                  out_last   = (emitted_ff + USED_W'(1)) == limit_ff;
                  emitted_in = emitted_ff + USED_W'(1);
               end
               if (take && out_last) begin
                  pend_in  = 1'b0;
                  used_in  = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else if (issue_ok) begin
                  rd_en   = 1'b1;
                  pend_in = 1'b1;
                  addr_in = addr_ff + USED_W'(1);
               end else begin
                  pend_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (wr_val_en) begin
         value_mem[wr_addr] <= wr_val;
      end
      if (wr_cnt_en) begin
         count_mem[wr_addr] <= wr_cnt;
      end
      if (rd_en) begin
         val_rd_ff <= value_mem[rd_addr];
         cnt_rd_ff <= count_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_value_ff <= item_value_in;
      item_last_ff  <= item_last_in;
      addr_ff       <= addr_in;
      pidx_ff       <= pidx_in;
      best_ff       <= best_in;
      ties_ff       <= ties_in;
      limit_ff      <= limit_in;
      emitted_ff    <= emitted_in;
      if (out_load) begin
         rsp_value_ff  <= out_value;
         rsp_count_ff  <= out_count;
         rsp_ovf_ff    <= ovf_ff;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - VALUE_W - COUNT_W - 1){1'b0}},
                        rsp_ovf_ff, rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(CAPACITY))
      else $error("fill count beyond table size");

   // Overflow is only raised once the table is full.
   assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> used_ff == USED_W'(CAPACITY))
      else $error("overflow raised with free table entries");

   // A no-mode result stands alone and reports a single occurrence.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_last_ff && rsp_count_ff == COUNT_W'(1)))
      else $error("malformed no-mode result");

endmodule

`default_nettype wire
